[src/button_gear_cruise_qualifier_assert.svh]
// assertion macros for the button gear and cruise qualifier
// each expects i_clk and i_rst_n in scope
`ifndef BUTTON_GEAR_CRUISE_QUALIFIER_ASSERT_SVH
`define BUTTON_GEAR_CRUISE_QUALIFIER_ASSERT_SVH

// condition must hold whenever the trigger holds, same edge
`define BGCQ_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition must hold on the edge after the trigger
`define BGCQ_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[src/bgcq_pkg.sv]
package bgcq_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned GEAR_W     = 3;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_W      = 16;

    localparam logic [GEAR_W-1:0] GEAR_TOP     = 3'd5;
    localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 3'd0;

    localparam logic KIND_GEAR   = 1'b0;
    localparam logic KIND_CRUISE = 1'b1;

    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd500;

    typedef struct packed {
        logic              kind;
        logic [GEAR_W-1:0] gear;
        logic              cruise;
    } t_event;

    // all events caused by one sample
    typedef struct packed {
        logic   two;
        t_event ev0;
        t_event ev1;
    } t_record;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[src/bgcq_front.sv]
module bgcq_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [bgcq_pkg::TIME_W-1:0]   i_now_ms,
    input  logic                          i_up_pressed,
    input  logic                          i_down_pressed,
    input  logic [bgcq_pkg::CFG_W-1:0]    i_settle_ms,
    input  logic [bgcq_pkg::CFG_W-1:0]    i_hold_ms,
    output logic                          o_push,
    output bgcq_pkg::t_record             o_rec
);
    import bgcq_pkg::*;

    logic [TIME_W-1:0] r_up_time, n_up_time;
    logic [TIME_W-1:0] r_down_start, n_down_start;
    logic              r_down_held, n_down_held;
    logic              r_long_fired, n_long_fired;
    logic [GEAR_W-1:0] r_gear, n_gear;
    logic              r_cruise, n_cruise;

    logic [TIME_W-1:0] w_up_dt;
    logic [TIME_W-1:0] w_down_dt;
    logic              w_up_hit;
    logic [GEAR_W-1:0] w_gear_up;
    logic              w_down_ev;
    t_event            w_up_ev;
    t_event            w_dn_ev;

    assign w_up_dt   = i_now_ms - r_up_time;
    assign w_down_dt = i_now_ms - r_down_start;
    assign w_up_hit  = i_up_pressed && (w_up_dt > {{(TIME_W-CFG_W){1'b0}}, i_settle_ms});
    assign w_gear_up = w_up_hit ? ((r_gear < GEAR_TOP) ? r_gear + 3'd1 : GEAR_NEUTRAL)
                                : r_gear;

    always_comb begin
        n_up_time    = r_up_time;
        n_down_start = r_down_start;
        n_down_held  = r_down_held;
        n_long_fired = r_long_fired;
        n_gear       = w_gear_up;
        n_cruise     = r_cruise;
        w_down_ev    = 1'b0;
        w_dn_ev.kind = KIND_GEAR;

        if (w_up_hit) begin
            n_up_time = i_now_ms;
        end

        if (i_down_pressed && !r_down_held) begin
            // hold start records the time only
            n_down_held  = 1'b1;
            n_down_start = i_now_ms;
            n_long_fired = 1'b0;
        end else if (i_down_pressed && !r_long_fired &&
                     (w_down_dt > {{(TIME_W-CFG_W){1'b0}}, i_hold_ms})) begin
            n_cruise     = !r_cruise;
            n_long_fired = 1'b1;
            w_down_ev    = 1'b1;
            w_dn_ev.kind = KIND_CRUISE;
        end else if (!i_down_pressed && r_down_held) begin
            if (!r_long_fired &&
                (w_down_dt > {{(TIME_W-CFG_W){1'b0}}, i_settle_ms})) begin
                n_gear    = (w_gear_up > GEAR_NEUTRAL && w_gear_up <= GEAR_TOP)
                            ? w_gear_up - 3'd1 : GEAR_TOP;
                w_down_ev = 1'b1;
            end
            n_down_held = 1'b0;
        end

        w_dn_ev.gear   = n_gear;
        w_dn_ev.cruise = n_cruise;
    end

    // up event reports the gear after the step and the cruise before any toggle
    assign w_up_ev.kind   = KIND_GEAR;
    assign w_up_ev.gear   = w_gear_up;
    assign w_up_ev.cruise = r_cruise;

    assign o_push    = i_accept && (w_up_hit || w_down_ev);
    assign o_rec.two = w_up_hit && w_down_ev;
    assign o_rec.ev0 = w_up_hit ? w_up_ev : w_dn_ev;
    assign o_rec.ev1 = w_dn_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_time    <= '0;
            r_down_start <= '0;
            r_down_held  <= 1'b0;
            r_long_fired <= 1'b0;
            r_gear       <= GEAR_NEUTRAL;
            r_cruise     <= 1'b0;
        end else if (i_accept) begin
            r_up_time    <= n_up_time;
            r_down_start <= n_down_start;
            r_down_held  <= n_down_held;
            r_long_fired <= n_long_fired;
            r_gear       <= n_gear;
            r_cruise     <= n_cruise;
        end
    end

endmodule

[src/bgcq_fifo.sv]
module bgcq_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  bgcq_pkg::t_record     i_rec,
    input  logic                  i_pop,
    output bgcq_pkg::t_record     o_rec,
    output bgcq_pkg::t_q_status   o_status
);
    import bgcq_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_record            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_rec          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[src/bgcq_back.sv]
module bgcq_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bgcq_pkg::t_q_status           i_q,
    input  bgcq_pkg::t_record             i_rec,
    output logic                          o_pop,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic                          o_event_kind,
    output logic [bgcq_pkg::GEAR_W-1:0]   o_gear,
    output logic                          o_cruise_on,
    output logic                          o_last
);
    import bgcq_pkg::*;

    logic   r_valid;
    t_event r_ev;
    logic   r_last;
    logic   r_pend;
    t_event r_pend_ev;
    logic   w_load;

    // output register free or being emptied this cycle
    assign w_load = !r_valid || !i_stall;
    assign o_pop  = w_load && !r_pend && !i_q.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (w_load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_q.empty) begin
                r_valid <= 1'b1;
                r_pend  <= i_rec.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_pend) begin
                r_ev   <= r_pend_ev;
                r_last <= 1'b1;
            end else begin
                r_ev      <= i_rec.ev0;
                r_last    <= !i_rec.two;
                r_pend_ev <= i_rec.ev1;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_event_kind = r_ev.kind;
    assign o_gear       = r_ev.gear;
    assign o_cruise_on  = r_ev.cruise;
    assign o_last       = r_last;

endmodule

[src/button_gear_cruise_qualifier.sv]
// button gear and cruise qualifier: takes one button sample per transaction
// (millisecond timestamp, up and down pressed flags) and reports gear steps
// and cruise toggles as result transactions, one to two per sample, the last
// one marked with o_last; samples that cause nothing give no result. a new
// sample is accepted every clock while the queue is not full: the front
// evaluates all debounce and hold timing for a sample combinationally and
// pushes its events as one record into a queue of QUEUE_DEPTH records. the
// back drains the queue through an output register at one result per clock
// while i_stall is low, so a sample with two events yields two results, and
// the output rate limits sustained throughput. each result is queued, then
// registered, before it is offered. o_stall is raised only while the queue
// is full. the user must write the debounce time (address 0) and long-press
// time (address 4) through the apb port while idle, unenforced by the block.
module button_gear_cruise_qualifier #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // sample channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [bgcq_pkg::TIME_W-1:0]       i_now_ms,
    input  logic                              i_up_pressed,
    input  logic                              i_down_pressed,

    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_event_kind,
    output logic [bgcq_pkg::GEAR_W-1:0]       o_gear,
    output logic                              o_cruise_on,
    output logic                              o_last,

    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bgcq_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import bgcq_pkg::*;

    `include "button_gear_cruise_qualifier_assert.svh"

    logic [CFG_W-1:0] r_settle_ms;
    logic [CFG_W-1:0] r_hold_ms;
    logic             w_cfg_wr;
    logic             w_reg_sel;

    logic             w_accept;
    logic             w_push;
    logic             w_pop;
    t_record          w_push_rec;
    t_record          w_head_rec;
    t_q_status        w_q;

    // register select from the word address, unused low bits ignored
    assign w_reg_sel = paddr[2];
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ms <= DEBOUNCE_RESET;
            r_hold_ms   <= LONG_PRESS_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_sel)
                REG_DEBOUNCE:   r_settle_ms <= pwdata[CFG_W-1:0];
                REG_LONG_PRESS: r_hold_ms   <= pwdata[CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_sel)
            REG_DEBOUNCE:   prdata = {16'b0, r_settle_ms};
            REG_LONG_PRESS: prdata = {16'b0, r_hold_ms};
            default:        prdata = '0;
        endcase
    end

    // front side stalls only on a full queue
    assign o_stall  = w_q.full;
    assign w_accept = i_valid && !o_stall;

    bgcq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_now_ms       (i_now_ms),
        .i_up_pressed   (i_up_pressed),
        .i_down_pressed (i_down_pressed),
        .i_settle_ms    (r_settle_ms),
        .i_hold_ms      (r_hold_ms),
        .o_push         (w_push),
        .o_rec          (w_push_rec)
    );

    bgcq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_rec    (w_push_rec),
        .i_pop    (w_pop),
        .o_rec    (w_head_rec),
        .o_status (w_q)
    );

    bgcq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q          (w_q),
        .i_rec        (w_head_rec),
        .o_pop        (w_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_event_kind (o_event_kind),
        .o_gear       (o_gear),
        .o_cruise_on  (o_cruise_on),
        .o_last       (o_last)
    );

    // a record is never pushed into a full queue
    `BGCQ_ASSERT_SAME(a_no_push_full, w_push, !w_q.full, "push into full queue")
    // gear stays within neutral and top gear
    `BGCQ_ASSERT_SAME(a_gear_range, o_valid, o_gear <= GEAR_TOP, "gear out of range")
    // a cruise toggle is always the final event of its sample
    `BGCQ_ASSERT_SAME(a_cruise_last, o_valid && o_event_kind, o_last,
        "cruise event not last")
    // the second event of a sample follows its first without a gap
    `BGCQ_ASSERT_NEXT(a_pair_follows, o_valid && !i_stall && !o_last, o_valid,
        "second event missing")

endmodule

[dv/button_gear_cruise_qualifier_test.sv]
`timescale 1ns / 1ps

module button_gear_cruise_qualifier_test;
    import bgcq_pkg::*;

    // one button sample as offered on the input channel
    typedef struct {
        logic [TIME_W-1:0] now;
        logic              up;
        logic              down;
    } t_button_sample;

    // one qualified event as it should leave the block
    typedef struct packed {
        logic              kind;
        logic [GEAR_W-1:0] gear;
        logic              cruise;
        logic              last;
    } t_qual_event;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;

    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [TIME_W-1:0]     i_now_ms = '0;
    logic                  i_up_pressed = 1'b0;
    logic                  i_down_pressed = 1'b0;

    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_event_kind;
    logic [GEAR_W-1:0]     o_gear;
    logic                  o_cruise_on;
    logic                  o_last;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    button_gear_cruise_qualifier DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_now_ms       (i_now_ms),
        .i_up_pressed   (i_up_pressed),
        .i_down_pressed (i_down_pressed),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_kind   (o_event_kind),
        .o_gear         (o_gear),
        .o_cruise_on    (o_cruise_on),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // samples waiting for the driver, events waiting for the monitor
    t_button_sample pending_samples[$];
    t_qual_event    expected_events[$];

    // predictor copy of the registers
    logic [CFG_W-1:0]  debounce_cfg   = DEBOUNCE_RESET;
    logic [CFG_W-1:0]  long_press_cfg = LONG_PRESS_RESET;

    // predictor copy of the qualifier state
    logic [TIME_W-1:0] up_accept_ms  = '0;
    logic [TIME_W-1:0] down_start_ms = '0;
    logic              down_tracked  = 1'b0;
    logic              long_done     = 1'b0;
    logic [GEAR_W-1:0] gear_now      = GEAR_NEUTRAL;
    logic              cruise_now    = 1'b0;

    // idling control, percent chance of starting a burst
    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned src_gap  = 0;
    int unsigned sink_hold = 0;

    // stimulus generator state
    logic [TIME_W-1:0] stim_ms = '0;
    logic              stim_up = 1'b0;
    logic              stim_down = 1'b0;
    int unsigned       stim_run = 0;

    int unsigned error_count   = 0;
    int unsigned samples_sent  = 0;
    int unsigned events_seen   = 0;
    int unsigned cruise_events = 0;
    int unsigned settings_used = 1;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // generous overall bound, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout at %0t, %0d events still outstanding", $time,
                 expected_events.size());
        $display("FAIL button_gear_cruise_qualifier");
        $finish;
    end

    // works out the events that one accepted sample causes and queues them
    task automatic qualify_sample(input logic [TIME_W-1:0] now, input logic up,
                                  input logic down);
        t_qual_event       evs[2];
        int                n;
        logic [TIME_W-1:0] since_up;
        logic [TIME_W-1:0] since_down;
        n = 0;
        since_up   = now - up_accept_ms;
        since_down = now - down_start_ms;

        // up step: level sampled, so a held button repeats once per debounce
        if (up && since_up > TIME_W'(debounce_cfg)) begin
            up_accept_ms = now;
            gear_now = (gear_now < GEAR_TOP) ? gear_now + 1'b1 : GEAR_NEUTRAL;
            evs[n] = '{kind: KIND_GEAR, gear: gear_now, cruise: cruise_now, last: 1'b0};
            n++;
        end

        // down: hold start only records the time, long hold toggles cruise,
        // release after a qualifying short hold steps the gear down
        if (down && !down_tracked) begin
            down_tracked  = 1'b1;
            down_start_ms = now;
            long_done     = 1'b0;
        end else if (down && !long_done && since_down > TIME_W'(long_press_cfg)) begin
            cruise_now = ~cruise_now;
            long_done  = 1'b1;
            evs[n] = '{kind: KIND_CRUISE, gear: gear_now, cruise: cruise_now, last: 1'b0};
            n++;
        end else if (!down && down_tracked) begin
            if (!long_done && since_down > TIME_W'(debounce_cfg)) begin
                gear_now = (gear_now > GEAR_NEUTRAL && gear_now <= GEAR_TOP)
                           ? gear_now - 1'b1 : GEAR_TOP;
                evs[n] = '{kind: KIND_GEAR, gear: gear_now, cruise: cruise_now, last: 1'b0};
                n++;
            end
            down_tracked = 1'b0;
        end

        if (n > 0) evs[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) expected_events.push_back(evs[k]);
    endtask

    // driver: offers queued samples, holds the payload while stalled
    always @(posedge i_clk) begin
        t_button_sample s;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                qualify_sample(i_now_ms, i_up_pressed, i_down_pressed);
                samples_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (pending_samples.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
                    // idle burst that begins with this cycle
                    src_gap = $urandom_range(7);
                    i_valid <= 1'b0;
                end else begin
                    s = pending_samples.pop_front();
                    i_now_ms       <= s.now;
                    i_up_pressed   <= s.up;
                    i_down_pressed <= s.down;
                    i_valid        <= 1'b1;
                end
            end
        end
    end

    // monitor: checks each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_qual_event want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                events_seen++;
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event kind=%0b gear=%0d cruise=%0b last=%0b",
                             $time, o_event_kind, o_gear, o_cruise_on, o_last);
                    error_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (want.kind == KIND_CRUISE) cruise_events++;
                    if (o_event_kind !== want.kind) begin
                        $display("%0t: event_kind expected %0b actual %0b",
                                 $time, want.kind, o_event_kind);
                        error_count++;
                    end
                    if (o_gear !== want.gear) begin
                        $display("%0t: gear expected %0d actual %0d",
                                 $time, want.gear, o_gear);
                        error_count++;
                    end
                    if (o_cruise_on !== want.cruise) begin
                        $display("%0t: cruise_on expected %0b actual %0b",
                                 $time, want.cruise, o_cruise_on);
                        error_count++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, o_last);
                        error_count++;
                    end
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                i_stall <= 1'b1;
            end else if (sink_stall_pct > 0 && $urandom_range(99) < sink_stall_pct) begin
                sink_hold = $urandom_range(7);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic add_sample(input logic [TIME_W-1:0] now, input logic up,
                              input logic down);
        pending_samples.push_back('{now: now, up: up, down: down});
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic reg_idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({reg_idx, 2'b00});
        // upper data bits carry noise, only the low 16 bits are meaningful
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == REG_DEBOUNCE) debounce_cfg = value;
        else long_press_cfg = value;
    endtask

    // random samples: button levels persist in runs so that holds and
    // repeats form, time steps cluster around the current thresholds
    task automatic queue_random_samples(input int unsigned count);
        logic [TIME_W-1:0] step;
        logic [TIME_W-1:0] db;
        logic [TIME_W-1:0] lp;
        db = TIME_W'(debounce_cfg);
        lp = TIME_W'(long_press_cfg);
        for (int unsigned k = 0; k < count; k++) begin
            case ($urandom_range(15))
                0:       step = '0;
                1, 2:    step = $urandom_range(3);
                3, 4:    step = db + $urandom_range(2) - 1;
                5, 6:    step = lp + $urandom_range(2) - 1;
                7, 8, 9: step = $urandom_range(2 * db + 2);
                10, 11:  step = $urandom_range(lp + 2);
                12:      step = $urandom;
                13:      step = -TIME_W'($urandom_range(1, 3));
                default: step = $urandom_range(100);
            endcase
            stim_ms = stim_ms + step;
            if (stim_run == 0) begin
                stim_run  = $urandom_range(1, 12);
                stim_up   = ($urandom_range(2) == 0);
                stim_down = 1'($urandom_range(1));
            end
            stim_run--;
            // occasional glitch sample outside the current run
            if ($urandom_range(9) == 0)
                add_sample(stim_ms, 1'($urandom_range(1)), 1'($urandom_range(1)));
            else add_sample(stim_ms, stim_up, stim_down);
        end
    endtask

    // lets the queued samples through and collects every outstanding event
    task automatic drain_phase();
        int unsigned guard;
        guard = 0;
        while (pending_samples.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_events.size() != 0 && guard < 2000) begin
            guard++;
            @(posedge i_clk);
        end
        while (expected_events.size() != 0) begin
            t_qual_event lost;
            lost = expected_events.pop_front();
            $display("%0t: missing event kind=%0b gear=%0d cruise=%0b last=%0b",
                     $time, lost.kind, lost.gear, lost.cruise, lost.last);
            error_count++;
        end
        // samples that produced nothing may still be in flight
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_W-1:0] db_set[8];
        logic [CFG_W-1:0] lp_set[8];

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset settings: debounce 50, long press 500
        src_idle_pct   = 20;
        sink_stall_pct = 20;
        add_sample(32'd0,   1'b1, 1'b0);  // up before debounce from zero is ignored
        add_sample(32'd50,  1'b1, 1'b0);  // exactly on the debounce time, ignored
        add_sample(32'd51,  1'b1, 1'b1);  // up step, down hold starts silently
        add_sample(32'd51,  1'b0, 1'b1);
        add_sample(32'd551, 1'b0, 1'b1);  // exactly on the long-press time
        add_sample(32'd552, 1'b1, 1'b1);  // up step then cruise toggle, two events
        add_sample(32'd600, 1'b0, 1'b1);  // long press already fired
        add_sample(32'd700, 1'b0, 1'b0);  // release after long press, no step
        add_sample(32'd800, 1'b0, 1'b1);
        add_sample(32'd850, 1'b0, 1'b0);  // short release, only ends the hold
        add_sample(32'd900, 1'b0, 1'b1);
        add_sample(32'd951, 1'b0, 1'b0);  // qualifying release, gear down
        for (int k = 0; k < 5; k++)       // up through the top gear and wrap
            add_sample(32'd1100 + 100 * k, 1'b1, 1'b0);
        add_sample(32'd1600, 1'b0, 1'b1);
        add_sample(32'd1700, 1'b0, 1'b0); // down from neutral gives top gear
        add_sample(32'hFFFF_FFF0, 1'b1, 1'b1);
        add_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
        add_sample(32'd5,   1'b1, 1'b1);  // wrapped difference below debounce
        add_sample(32'h30,  1'b1, 1'b0);  // wrapped difference above debounce
        add_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
        add_sample(32'hAAAA_5555, 1'b0, 1'b1);
        add_sample(32'h5555_AAAA, 1'b0, 1'b1); // long hold across a big jump
        drain_phase();

        // extremes first, then random settings, reset values again at the end
        db_set = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, DEBOUNCE_RESET};
        lp_set = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, LONG_PRESS_RESET};
        for (int p = 4; p < 7; p++) begin
            db_set[p] = CFG_W'($urandom_range(200));
            lp_set[p] = CFG_W'($urandom_range(1000));
        end
        stim_ms = 32'h0000_1000;

        for (int p = 0; p < 8; p++) begin
            write_reg(REG_DEBOUNCE, db_set[p]);
            write_reg(REG_LONG_PRESS, lp_set[p]);
            settings_used++;
            // a mid-run stretch and the closing stretch run without idling
            if (p == 3 || p == 7) begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end else begin
                src_idle_pct   = $urandom_range(10, 40);
                sink_stall_pct = $urandom_range(10, 40);
            end
            queue_random_samples(220);
            drain_phase();
        end

        $display("covered %0d samples and %0d events (%0d cruise toggles)",
                 samples_sent, events_seen, cruise_events);
        $display("over %0d register settings including both extremes", settings_used);
        if (error_count == 0) begin
            $display("PASS button_gear_cruise_qualifier");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL button_gear_cruise_qualifier");
        end
        $finish;
    end

endmodule
